FILE: rtl/core/shn_pkg.sv
// ----------------------------------------------------------------------------
// shn_pkg
// Types and hash step functions shared by the seeded name hash modules.
// ----------------------------------------------------------------------------
`default_nettype none

package shn_pkg;

    localparam int HashWidth = 32;
    localparam int PendWidth = 24;
    localparam int CountWidth = 2;

    typedef logic [HashWidth-1:0]  hash_t;
    typedef logic [PendWidth-1:0]  pend_t;
    typedef logic [CountWidth-1:0] count_t;

    localparam count_t CountFull = 2'd3;

    typedef struct packed {
        hash_t  hash;
        pend_t  bytes;
        count_t count;
    } shn_fin_req_t;

    function automatic hash_t mix_group(input hash_t h_in, input logic [15:0] lo,
                                        input logic [15:0] hi);
        hash_t h;
        hash_t t;
        h = h_in + {16'd0, lo};
        t = {5'd0, hi, 11'd0} ^ h;
        h = {h[15:0], 16'd0} ^ t;
        h = h + {11'd0, h[31:11]};
        return h;
    endfunction

    function automatic hash_t tail_step(input hash_t h_in, input pend_t bytes,
                                        input count_t count);
        hash_t h;
        h = h_in;
        unique case (count)
            2'd3:
            begin
                h = h + {16'd0, bytes[15:0]};
                h = h ^ {h[15:0], 16'd0};
                h = h ^ {6'd0, bytes[23:16], 18'd0};
                h = h + {11'd0, h[31:11]};
            end
            2'd2:
            begin
                h = h + {16'd0, bytes[15:0]};
                h = h ^ {h[20:0], 11'd0};
                h = h + {17'd0, h[31:17]};
            end
            2'd1:
            begin
                h = h + {24'd0, bytes[7:0]};
                h = h ^ {h[21:0], 10'd0};
                h = h + {1'd0, h[31:1]};
            end
            default:
            begin
                h = h_in;
            end
        endcase
        return h;
    endfunction

    function automatic hash_t avalanche_a(input hash_t h_in);
        hash_t h;
        h = h_in ^ {h_in[28:0], 3'd0};
        h = h + {5'd0, h[31:5]};
        h = h ^ {h[27:0], 4'd0};
        h = h + {17'd0, h[31:17]};
        return h;
    endfunction

    function automatic hash_t avalanche_b(input hash_t h_in);
        hash_t h;
        h = h_in ^ {h_in[6:0], 25'd0};
        h = h + {6'd0, h[31:6]};
        return h;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/shn_accum.sv
// ----------------------------------------------------------------------------
// shn_accum
// Running hash state: loads the seed, gathers bytes and mixes whole groups.
// ----------------------------------------------------------------------------
`default_nettype none

module shn_accum (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 accept,
    input  wire logic [31:0]          parent_id,
    input  wire logic [15:0]          volume_id,
    input  wire logic [7:0]           name_byte,
    input  wire logic                 has_byte,
    input  wire logic                 last,
    output logic                      fin_valid,
    output shn_pkg::shn_fin_req_t     fin_req
);
    import shn_pkg::*;

    hash_t  hash_reg;
    hash_t  hash_next;
    pend_t  pend_reg;
    pend_t  pend_next;
    count_t count_reg;
    count_t count_next;
    logic   inside_reg;
    logic   inside_next;

    hash_t  seed;
    hash_t  h_base;
    pend_t  b_base;
    count_t c_base;
    hash_t  h_new;
    pend_t  b_new;
    count_t c_new;

    assign seed   = parent_id + {16'd0, volume_id};
    assign h_base = inside_reg ? hash_reg : seed;
    assign b_base = inside_reg ? pend_reg : '0;
    assign c_base = inside_reg ? count_reg : '0;

    always_comb
    begin
        h_new = h_base;
        b_new = b_base;
        c_new = c_base;
        if (has_byte)
        begin
            unique case (c_base)
                2'd0:
                begin
                    b_new[7:0] = name_byte;
                    c_new      = 2'd1;
                end
                2'd1:
                begin
                    b_new[15:8] = name_byte;
                    c_new       = 2'd2;
                end
                2'd2:
                begin
                    b_new[23:16] = name_byte;
                    c_new        = CountFull;
                end
                default:
                begin
                    h_new = mix_group(hash_reg, pend_reg[15:0], {name_byte, pend_reg[23:16]});
                    b_new = '0;
                    c_new = '0;
                end
            endcase
        end
    end

    assign fin_valid     = accept && last;
    assign fin_req.hash  = h_new;
    assign fin_req.bytes = b_new;
    assign fin_req.count = c_new;

    always_comb
    begin
        hash_next   = hash_reg;
        pend_next   = pend_reg;
        count_next  = count_reg;
        inside_next = inside_reg;
        if (accept)
        begin
            if (last)
            begin
                hash_next   = '0;
                pend_next   = '0;
                count_next  = '0;
                inside_next = 1'b0;
            end
            else
            begin
                hash_next   = h_new;
                pend_next   = b_new;
                count_next  = c_new;
                inside_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg   <= '0;
            pend_reg   <= '0;
            count_reg  <= '0;
            inside_reg <= 1'b0;
        end
        else
        begin
            hash_reg   <= hash_next;
            pend_reg   <= pend_next;
            count_reg  <= count_next;
            inside_reg <= inside_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/shn_finish.sv
// ----------------------------------------------------------------------------
// shn_finish
// Finishing pipeline: request register, tail step, avalanche in two halves, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module shn_finish (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 req_valid,
    input  wire shn_pkg::shn_fin_req_t req,
    output logic                      req_ready,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [31:0]               hash_value
);
    import shn_pkg::*;

    logic         s1_valid_reg;
    logic         s1_valid_next;
    shn_fin_req_t s1_reg;
    logic         s2_valid_reg;
    logic         s2_valid_next;
    hash_t        s2_reg;
    logic         s3_valid_reg;
    logic         s3_valid_next;
    hash_t        s3_reg;
    logic         out_valid_reg;
    logic         out_valid_next;
    hash_t        out_reg;

    logic out_free;
    logic s3_free;
    logic s2_free;
    logic s1_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign s3_free   = !s3_valid_reg || out_free;
    assign s2_free   = !s2_valid_reg || s3_free;
    assign s1_free   = !s1_valid_reg || s2_free;
    assign req_ready = s1_free;

    assign s1_valid_next  = s1_free  ? req_valid    : s1_valid_reg;
    assign s2_valid_next  = s2_free  ? s1_valid_reg : s2_valid_reg;
    assign s3_valid_next  = s3_free  ? s2_valid_reg : s3_valid_reg;
    assign out_valid_next = out_free ? s3_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            s3_valid_reg  <= s3_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_free && req_valid)
        begin
            s1_reg <= req;
        end
        if (s2_free && s1_valid_reg)
        begin
            s2_reg <= tail_step(s1_reg.hash, s1_reg.bytes, s1_reg.count);
        end
        if (s3_free && s2_valid_reg)
        begin
            s3_reg <= avalanche_a(s2_reg);
        end
        if (out_free && s3_valid_reg)
        begin
            out_reg <= avalanche_b(s3_reg);
        end
    end

    assign out_valid  = out_valid_reg;
    assign hash_value = out_reg;

endmodule

`default_nettype wire

FILE: rtl/core/seeded_name_hash.sv
// ----------------------------------------------------------------------------
// seeded_name_hash
// Seeded 32-bit SuperFastHash over the bytes of a name, one byte per item.
//
// The input channel (in_valid, in_ready) carries one name byte per item,
// with the parent and volume ids, which form the seed on a name's first item.
// An item with has_byte low adds no byte; last marks the final item.
// The output channel (out_valid, out_ready) gives one hash_value per name.
// Names stream at one byte per clock while in_ready is high, and a new name
// may start in the cycle after the last item of the previous one. Whole
// four-byte groups are mixed in the accumulator. The tail step and avalanche
// run in the finishing pipeline, which registers the request, the tail step
// result and each avalanche half in turn. Up to four finished names can be
// held while the receiver stalls; in_ready drops only when all of those
// places are occupied.
// Reset clears the running hash and empties the finishing pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module seeded_name_hash (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [31:0] parent_id,
    input  wire logic [15:0] volume_id,
    input  wire logic [7:0]  name_byte,
    input  wire logic        has_byte,
    input  wire logic        last,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      hash_value
);
    import shn_pkg::*;

    logic         accept;
    logic         fin_valid;
    logic         fin_ready;
    shn_fin_req_t fin_req;

    assign in_ready = fin_ready;
    assign accept   = in_valid && in_ready;

    shn_accum u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .parent_id (parent_id),
        .volume_id (volume_id),
        .name_byte (name_byte),
        .has_byte  (has_byte),
        .last      (last),
        .fin_valid (fin_valid),
        .fin_req   (fin_req)
    );

    shn_finish u_finish (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (fin_valid),
        .req        (fin_req),
        .req_ready  (fin_ready),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .hash_value (hash_value)
    );

    a_ready_only_when_full: assert property (
        @(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready)
    ) else $error("input stalled while the output was free");

    a_finish_only_on_last: assert property (
        @(posedge clk) disable iff (!rst_n)
        fin_valid |-> (in_valid && in_ready && last)
    ) else $error("finish request without an accepted last item");

    a_stall_holds_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && !in_ready) || out_valid
    ) else $error("stalled result was dropped");

endmodule

`default_nettype wire
